// ===== rtl/tqss_pkg.sv =====
// Package for the terminal query stream splitter.
// Holds the parser state encoding, result kinds, control byte values and the
// command and status structs shared by the controller and the datapath.
`default_nettype none

package tqss_pkg;

	// Parser state. The first four follow the parse modes, and the last one
	// drains a buffered escape sequence.
	typedef enum logic [2:0] {
		ST_TEXT,
		ST_MARKER,
		ST_QUERY,
		ST_ESCAPE,
		ST_FLUSH
	} tqss_state_t;

	// Result kinds.
	localparam logic [1:0] KIND_TEXT  = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	// Control bytes.
	localparam logic [7:0] BYTE_MARKER = 8'h01;
	localparam logic [7:0] BYTE_Q      = 8'h51;
	localparam logic [7:0] BYTE_EOT    = 8'h04;
	localparam logic [7:0] BYTE_ESC    = 8'h1B;
	localparam logic [7:0] BYTE_M      = 8'h6D;

	// Source of the next result loaded into the output register.
	typedef enum logic [1:0] {
		SEL_TEXT,
		SEL_QUERY,
		SEL_DONE,
		SEL_STORE
	} tqss_sel_t;

	typedef struct packed {
		logic      ld_out;
		tqss_sel_t out_sel;
		logic      esc_start;
		logic      esc_push;
		logic      rd_clr;
		logic      rd_inc;
	} tqss_cmd_t;

	typedef struct packed {
		logic is_marker;
		logic is_q;
		logic is_eot;
		logic is_esc;
		logic is_m;
		logic push_full;
		logic rd_last;
	} tqss_status_t;

endpackage

`default_nettype wire

// ===== rtl/tqss_ctrl.sv =====
// Controller state machine of the terminal query stream splitter.
// Depends on tqss_pkg; drives the datapath by commands and owns both handshakes.
`default_nettype none

module tqss_ctrl
	import tqss_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire logic         out_ready,
	input  wire tqss_status_t st,
	output tqss_cmd_t         cmd
);

	tqss_state_t state_q, state_d;
	logic        out_valid_q, out_valid_d;
	logic        slot_free;
	logic        acc;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_TEXT;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.out_sel = SEL_TEXT;
		in_ready    = (state_q != ST_FLUSH) && slot_free;
		acc         = in_valid && in_ready;
		unique case (state_q)
			ST_TEXT: begin
				if (acc) begin
					if (st.is_marker) begin
						state_d = ST_MARKER;
					end else if (st.is_esc) begin
						cmd.esc_start = 1'b1;
						state_d       = ST_ESCAPE;
					end else begin
						cmd.ld_out  = 1'b1;
						cmd.out_sel = SEL_TEXT;
					end
				end
			end
			ST_MARKER: begin
				if (acc) begin
					state_d = st.is_q ? ST_QUERY : ST_TEXT;
				end
			end
			ST_QUERY: begin
				if (acc) begin
					cmd.ld_out = 1'b1;
					if (st.is_eot) begin
						cmd.out_sel = SEL_DONE;
						state_d     = ST_TEXT;
					end else begin
						cmd.out_sel = SEL_QUERY;
					end
				end
			end
			ST_ESCAPE: begin
				if (acc) begin
					cmd.esc_push = 1'b1;
					if (st.is_m || st.push_full) begin
						cmd.rd_clr = 1'b1;
						state_d    = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (slot_free) begin
					cmd.ld_out  = 1'b1;
					cmd.out_sel = SEL_STORE;
					cmd.rd_inc  = 1'b1;
					if (st.rd_last) begin
						state_d = ST_TEXT;
					end
				end
			end
			default: begin
				state_d = ST_TEXT;
			end
		endcase
		if (cmd.ld_out) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_flush_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |-> !in_ready)
		else $error("input accepted while draining an escape sequence");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |-> slot_free)
		else $error("pending result overwritten");
	a_flush_follows_escape: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) && !$past(state_q == ST_FLUSH) |-> $past(state_q == ST_ESCAPE))
		else $error("flush entered from a state other than escape");
`endif

endmodule

`default_nettype wire

// ===== rtl/tqss_dpath.sv =====
// Datapath of the terminal query stream splitter: escape buffer, its fill
// count and read pointer, and the output result register. Depends on tqss_pkg.
`default_nettype none

module tqss_dpath
	import tqss_pkg::*;
#(
	parameter int ESC_MAX_LEN = 11
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] in_byte,
	input  wire tqss_cmd_t  cmd,
	output tqss_status_t    st,
	output logic [1:0]      item_kind,
	output logic [7:0]      out_byte,
	output logic            run_last
);

	localparam int CW = $clog2(ESC_MAX_LEN + 1);
	localparam int IW = $clog2(ESC_MAX_LEN);
	localparam logic [CW-1:0] FULL_AT = CW'(ESC_MAX_LEN - 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(ESC_MAX_LEN);

	logic [7:0]    esc_mem_q [ESC_MAX_LEN];
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] rd_q;
	logic [CW-1:0] rd_next;

	assign rd_next = {{(CW - IW){1'b0}}, rd_q} + CW'(1);

	always_comb begin
		st.is_marker = (in_byte == BYTE_MARKER);
		st.is_q      = (in_byte == BYTE_Q);
		st.is_eot    = (in_byte == BYTE_EOT);
		st.is_esc    = (in_byte == BYTE_ESC);
		st.is_m      = (in_byte == BYTE_M);
		st.push_full = (cnt_q == FULL_AT);
		st.rd_last   = (rd_next == cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else begin
			if (cmd.esc_start) begin
				cnt_q <= CW'(1);
			end else if (cmd.esc_push) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.rd_clr) begin
				rd_q <= '0;
			end else if (cmd.rd_inc) begin
				rd_q <= rd_next[IW-1:0];
			end
		end
	end

	// Buffer and result payload carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.esc_start) begin
			esc_mem_q[0] <= in_byte;
		end else if (cmd.esc_push) begin
			esc_mem_q[cnt_q[IW-1:0]] <= in_byte;
		end
		if (cmd.ld_out) begin
			case (cmd.out_sel)
				SEL_TEXT: begin
					item_kind <= KIND_TEXT;
					out_byte  <= in_byte;
					run_last  <= 1'b1;
				end
				SEL_QUERY: begin
					item_kind <= KIND_QUERY;
					out_byte  <= in_byte;
					run_last  <= 1'b0;
				end
				SEL_DONE: begin
					item_kind <= KIND_DONE;
					out_byte  <= 8'h00;
					run_last  <= 1'b0;
				end
				default: begin
					item_kind <= KIND_TEXT;
					out_byte  <= esc_mem_q[rd_q];
					run_last  <= st.rd_last;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT)
		else $error("escape count beyond buffer depth");
	a_push_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.esc_push |-> (cnt_q != '0) && (cnt_q < MAX_CNT))
		else $error("escape byte pushed outside the buffer");
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_inc |-> (rd_next <= cnt_q))
		else $error("escape buffer read past its fill count");
`endif

endmodule

`default_nettype wire

// ===== rtl/terminal_query_stream_splitter_core.sv =====
// Top level of the terminal query stream splitter.
// Instantiates tqss_ctrl and tqss_dpath; depends on tqss_pkg.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_ready   in_byte[7:0]
//   output   out        out_valid / out_ready item_kind[1:0], out_byte[7:0], run_last
//
// A request carrying a plain text byte, a query byte or the end-of-query byte
// loads one result into the output register at its acceptance edge. The next
// request is accepted only while that register is empty or is being emptied at
// the same edge, so a stalled result holds off the input.
// The byte that closes an escape sequence starts a drain of the buffered bytes,
// one buffered byte per cycle, the sequence being at most ESC_MAX_LEN bytes long;
// no request is accepted during the drain, and output stalls stretch it.
// Reset is asynchronous and active low and returns the parser to text mode.
`default_nettype none

module terminal_query_stream_splitter_core
	import tqss_pkg::*;
#(
	parameter int ESC_MAX_LEN = 11
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      item_kind,
	output logic [7:0]      out_byte,
	output logic            run_last
);

	// Commands flow from the controller to the datapath, and byte class and
	// buffer status flow back.
	tqss_cmd_t    cmd;
	tqss_status_t st;

	// The controller owns both handshakes and the output valid flag. It
	// accepts a request only when the output register is free or being
	// emptied in the same cycle, so a result is never lost.
	tqss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// The datapath holds the escape buffer and the result register. A marker
	// byte followed by anything but 'Q' produces no result at all.
	tqss_dpath #(
		.ESC_MAX_LEN (ESC_MAX_LEN)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (in_byte),
		.cmd       (cmd),
		.st        (st),
		.item_kind (item_kind),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

endmodule

`default_nettype wire

// ===== tb/tqss_split_monitor.sv =====
// Scoreboard for the terminal query stream splitter: watches both request channels,
// predicts the result stream from accepted input bytes and compares it field by field.
// Depends on tqss_pkg for result kinds and control byte values.
module tqss_split_monitor
	import tqss_pkg::*;
#(
	parameter int ESC_MAX_LEN = 11
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [1:0] item_kind,
	input  logic [7:0] out_byte,
	input  logic       run_last,
	output int         errors,
	output int         waiting,
	output int         checked,
	output int         queries_closed,
	output int         escape_runs
);

	typedef enum logic [1:0] {
		PM_TEXT,
		PM_MARKER,
		PM_QUERY,
		PM_ESCAPE
	} parse_mode_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} split_item_t;

	parse_mode_t  mode;
	logic [7:0]   esc_buf [ESC_MAX_LEN];
	int           esc_len;
	split_item_t  expected_items [$];
	int           err_cnt;
	int           check_cnt;
	int           done_cnt;
	int           run_cnt;

	function automatic void push_item(input logic [1:0] kind, input logic [7:0] data,
			input logic last);
		split_item_t it;
		it.kind = kind;
		it.data = data;
		it.last = last;
		expected_items.push_back(it);
	endfunction

	task automatic split_byte(input logic [7:0] b);
		int i;
		case (mode)
			PM_TEXT: begin
				if (b == BYTE_MARKER) begin
					mode = PM_MARKER;
				end else if (b == BYTE_ESC) begin
					mode = PM_ESCAPE;
					esc_buf[0] = b;
					esc_len = 1;
				end else begin
					push_item(KIND_TEXT, b, 1'b1);
				end
			end
			PM_MARKER: begin
				// Anything but 'Q' drops the marker and this byte silently.
				mode = (b == BYTE_Q) ? PM_QUERY : PM_TEXT;
			end
			PM_QUERY: begin
				if (b == BYTE_EOT) begin
					push_item(KIND_DONE, 8'h00, 1'b0);
					mode = PM_TEXT;
				end else begin
					push_item(KIND_QUERY, b, 1'b0);
				end
			end
			default: begin
				esc_buf[esc_len] = b;
				esc_len++;
				if (b == BYTE_M || esc_len >= ESC_MAX_LEN) begin
					for (i = 0; i < esc_len; i++)
						push_item(KIND_TEXT, esc_buf[i], i == esc_len - 1);
					esc_len = 0;
					run_cnt++;
					mode = PM_TEXT;
				end
			end
		endcase
	endtask

	task automatic check_result();
		split_item_t want;
		if (expected_items.size() == 0) begin
			$display("%0t: unexpected result kind=%0d byte=%02h last=%0b", $time,
				item_kind, out_byte, run_last);
			err_cnt++;
		end else begin
			want = expected_items.pop_front();
			if (item_kind !== want.kind) begin
				$display("%0t: item_kind expected %0d, actual %0d", $time, want.kind,
					item_kind);
				err_cnt++;
			end
			if (out_byte !== want.data) begin
				$display("%0t: out_byte expected %02h, actual %02h", $time, want.data,
					out_byte);
				err_cnt++;
			end
			if (run_last !== want.last) begin
				$display("%0t: run_last expected %0b, actual %0b", $time, want.last,
					run_last);
				err_cnt++;
			end
			check_cnt++;
			if (want.kind == KIND_DONE)
				done_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = PM_TEXT;
			esc_len = 0;
			expected_items.delete();
			err_cnt = 0;
			check_cnt = 0;
			done_cnt = 0;
			run_cnt = 0;
			errors <= 0;
			waiting <= 0;
			checked <= 0;
			queries_closed <= 0;
			escape_runs <= 0;
		end else begin
			// A result never leaves in the cycle its byte is taken, so the order is free.
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				split_byte(in_byte);
			errors <= err_cnt;
			waiting <= expected_items.size();
			checked <= check_cnt;
			queries_closed <= done_cnt;
			escape_runs <= run_cnt;
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the terminal query stream splitter testbench: clock, reset, byte stimulus,
// receiver backpressure and the final verdict. Depends on tqss_pkg, the core and
// the tqss_split_monitor scoreboard.
module testbench;
	import tqss_pkg::*;

	localparam int ESC_LEN = 11;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       out_ready = 1'b0;
	wire        in_ready;
	wire        out_valid;
	wire  [1:0] item_kind;
	wire  [7:0] out_byte;
	wire        run_last;

	// Idle rates in percent for the sending and the receiving side.
	int in_idle_pct = 9;
	int out_idle_pct = 52;
	int requests_sent = 0;

	int errors;
	int waiting;
	int checked;
	int queries_closed;
	int escape_runs;

	terminal_query_stream_splitter_core #(
		.ESC_MAX_LEN(ESC_LEN)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.item_kind(item_kind),
		.out_byte (out_byte),
		.run_last (run_last)
	);

	tqss_split_monitor #(
		.ESC_MAX_LEN(ESC_LEN)
	) monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.item_kind     (item_kind),
		.out_byte      (out_byte),
		.run_last      (run_last),
		.errors        (errors),
		.waiting       (waiting),
		.checked       (checked),
		.queries_closed(queries_closed),
		.escape_runs   (escape_runs)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The receiver stalls at random, at the rate of the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_idle_pct);
	end

	// Hard stop in case the block hangs; far beyond the slowest legal run.
	initial begin
		#4000000;
		$display("CHECK FAILED");
		$finish;
	end

	// Offers one request and returns at the edge where it is accepted. Random
	// idle cycles go in front of the request; valid is never dropped once raised.
	task automatic offer_byte(input logic [7:0] b);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (!in_ready);
		requests_sent++;
	endtask

	// Holds the input quiet until every predicted result has been seen. The
	// first edge is waited out so that the scoreboard has counted the last request.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
	endtask

	// A random byte that is neither of two given values.
	function automatic logic [7:0] pick_except(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		do x = 8'($urandom_range(255)); while (x == a || x == b);
		return x;
	endfunction

	// Mostly well-formed frames with random content: plain text, complete
	// queries, escape runs closed by 'm' or by the length limit. The rest is
	// markers not followed by 'Q' and fully random noise, which may leave the
	// parser in any mode for the frames that follow.
	task automatic random_frames(input int count);
		int target;
		int pick;
		int n;
		int i;
		target = requests_sent + count;
		while (requests_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				offer_byte(pick_except(BYTE_MARKER, BYTE_ESC));
			end else if (pick < 55) begin
				offer_byte(BYTE_MARKER);
				offer_byte(BYTE_Q);
				n = $urandom_range(6);
				for (i = 0; i < n; i++)
					offer_byte(pick_except(BYTE_EOT, BYTE_EOT));
				offer_byte(BYTE_EOT);
			end else if (pick < 80) begin
				offer_byte(BYTE_ESC);
				if ($urandom_range(3) == 0) begin
					// Runs into the length limit without a closing 'm'.
					for (i = 1; i < ESC_LEN; i++)
						offer_byte(pick_except(BYTE_M, BYTE_M));
				end else begin
					n = $urandom_range(ESC_LEN - 3);
					for (i = 0; i < n; i++)
						offer_byte(pick_except(BYTE_M, BYTE_M));
					offer_byte(BYTE_M);
				end
			end else if (pick < 88) begin
				offer_byte(BYTE_MARKER);
				offer_byte(pick_except(BYTE_Q, BYTE_Q));
			end else begin
				offer_byte(8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		logic [7:0] directed [$];

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: byte extremes as plain text, a query carrying the
		// marker, ESC and 'm' as payload, an empty query, a marker that eats the
		// next marker, a two-byte escape, and an escape holding control bytes that
		// is flushed by the length limit.
		directed = {8'h00, 8'hFF,
			BYTE_MARKER, BYTE_Q, BYTE_MARKER, BYTE_ESC, BYTE_M, BYTE_EOT,
			BYTE_MARKER, BYTE_Q, BYTE_EOT,
			BYTE_MARKER, BYTE_MARKER,
			BYTE_ESC, BYTE_M,
			BYTE_ESC, BYTE_MARKER, BYTE_EOT, BYTE_ESC, 8'h5B, 8'h33, 8'h31, 8'h3B,
			8'h34, 8'h32, 8'hFF};
		foreach (directed[i])
			offer_byte(directed[i]);

		// The sender pauses here until the block has emptied completely.
		drain_results();

		// Phase one: light sender idling, heavy receiver stalls.
		random_frames(65);

		// Phase two: the other way round.
		in_idle_pct <= 52;
		out_idle_pct <= 9;
		random_frames(65);
		drain_results();

		// Phase three: both sides run flat out.
		in_idle_pct <= 0;
		out_idle_pct <= 0;
		random_frames(65);

		drain_results();
		// An escape flush is the longest the block stays busy after its last result.
		repeat (2 * ESC_LEN) @(posedge clk);

		$display("Run covered %0d input bytes and %0d checked results,", requests_sent,
			checked);
		$display("including %0d closed queries and %0d flushed escape runs.",
			queries_closed, escape_runs);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
